@@ rtl/core/ssm_pkg.sv @@
// Package for the streaming substring matcher: sizes, payload types, register codes, helpers.
package ssm_pkg;

	localparam int PATTERN_MAX   = 32;
	localparam int POSITION_BITS = 16;

	localparam int BYTE_W     = 8;
	localparam int PAT_BYTES  = 32;   // bytes held by the four pattern registers
	localparam int PAT_SEL_W  = 5;    // index width into the pattern bytes
	localparam int LEN_W      = 6;
	localparam int MATCH_W    = 16;
	localparam int CNT_W      = POSITION_BITS + 1;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IGN_CASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RPT_LAST  = 3'd6;

	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

	typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_t;
	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0]   pattern_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [MATCH_W-1:0] match_start;
		logic               position_overflow;
	} out_item_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
		input logic ign);
		if (ign && (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
			fold_byte = b + ASCII_CASE_OFS;
		end else begin
			fold_byte = b;
		end
	endfunction

endpackage

@@ rtl/core/ssm_window_cmp.sv @@
// Window compare: checks the newest pattern_length window bytes against the pattern.
module ssm_window_cmp (
	input  ssm_pkg::window_t              window,
	input  ssm_pkg::pattern_t             pattern,
	input  logic [ssm_pkg::LEN_W-1:0]     pat_len,
	input  logic                          ignore_case,
	output logic                          hit
);

	logic [ssm_pkg::PATTERN_MAX-1:0] lane_ok;
	logic                            len_ok;

	// window entry k lines up with pattern byte len-1-k
	always_comb begin
		logic [ssm_pkg::LEN_W-1:0] pidx;
		logic [ssm_pkg::LEN_W-1:0] kk;
		for (int k = 0; k < ssm_pkg::PATTERN_MAX; k++) begin
			kk   = ssm_pkg::LEN_W'(k);
			pidx = pat_len - kk - ssm_pkg::LEN_W'(1);
			if (kk >= pat_len) begin
				lane_ok[k] = 1'b1;
			end else begin
				lane_ok[k] = ssm_pkg::fold_byte(window[k], ignore_case) ==
					ssm_pkg::fold_byte(pattern[pidx[ssm_pkg::PAT_SEL_W-1:0]], ignore_case);
			end
		end
	end

	assign len_ok = (pat_len != '0) &&
		(pat_len <= ssm_pkg::LEN_W'(ssm_pkg::PATTERN_MAX));
	assign hit = len_ok && (&lane_ok);

endmodule

@@ rtl/core/streaming_substring_matcher.sv @@
// Top level of the streaming substring matcher.
// Text enters one byte per transaction on the in channel, the final byte of a text
// flagged by end_of_text; one result transaction leaves on the out channel for each
// final byte and none for other bytes. The block sustains one byte per clock: a byte
// is registered in the input stage, where the newest pattern_length bytes of the window
// are compared with the pattern in parallel, one lane per window byte, and the match
// state is updated. A final byte's result is then held in the result register. Bytes
// keep flowing while a result waits on the out channel; only a final byte that finds
// the result register still full holds the input stage. Configuration is written by
// index through cfg_we/cfg_index/cfg_data and applies to the next byte processed.
// Offsets saturate at 2^POSITION_BITS; later bytes still shift through the window but
// cannot end a reported match, and set position_overflow for the text.
module streaming_substring_matcher (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// text in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ssm_pkg::in_item_t                 in_item,
	// result out
	output logic                              out_valid,
	input  logic                              out_stall,
	output ssm_pkg::out_item_t                out_item
);

	// config registers
	ssm_pkg::pattern_t                pattern_q;
	logic [ssm_pkg::LEN_W-1:0]        pat_len_q;
	logic                             ign_case_q;
	logic                             rpt_last_q;

	// input stage
	logic                             valid_s1;
	ssm_pkg::in_item_t                item_s1;

	// per-text state
	ssm_pkg::window_t                 window_q;
	logic [ssm_pkg::CNT_W-1:0]        seen_q;
	logic                             have_q;
	logic [ssm_pkg::MATCH_W-1:0]      best_q;
	logic                             ovf_q;

	// result register
	logic                             out_valid_q;
	ssm_pkg::out_item_t               out_item_q;

	logic                             out_free;
	logic                             s1_go;
	logic                             in_take;
	ssm_pkg::window_t                 window_nx;
	logic                             win_hit;
	logic                             saturated;
	logic [ssm_pkg::CNT_W-1:0]        seen_inc;
	logic [ssm_pkg::CNT_W-1:0]        start_full;
	logic                             rec_match;
	logic                             have_nx;
	logic [ssm_pkg::MATCH_W-1:0]      best_nx;
	logic                             ovf_nx;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			pat_len_q  <= '0;
			ign_case_q <= 1'b0;
			rpt_last_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssm_pkg::CFG_PAT_0_7:   pattern_q[7:0]   <= cfg_data;
				ssm_pkg::CFG_PAT_8_15:  pattern_q[15:8]  <= cfg_data;
				ssm_pkg::CFG_PAT_16_23: pattern_q[23:16] <= cfg_data;
				ssm_pkg::CFG_PAT_24_31: pattern_q[31:24] <= cfg_data;
				ssm_pkg::CFG_PAT_LEN:   pat_len_q  <= cfg_data[ssm_pkg::LEN_W-1:0];
				ssm_pkg::CFG_IGN_CASE:  ign_case_q <= cfg_data[0];
				ssm_pkg::CFG_RPT_LAST:  rpt_last_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// result register can take a new transaction if empty or draining this cycle
	assign out_free = !out_valid_q || !out_stall;
	// stage 1 retires unless it holds a final byte with nowhere to put the result
	assign s1_go    = valid_s1 && (!item_s1.end_of_text || out_free);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// ---------------- match datapath ----------------
	always_comb begin
		window_nx[0] = item_s1.text_byte;
		for (int k = 1; k < ssm_pkg::PATTERN_MAX; k++) begin
			window_nx[k] = window_q[k-1];
		end
	end

	ssm_window_cmp u_cmp (
		.window      (window_nx),
		.pattern     (pattern_q),
		.pat_len     (pat_len_q),
		.ignore_case (ign_case_q),
		.hit         (win_hit)
	);

	assign saturated  = seen_q[ssm_pkg::POSITION_BITS];
	assign seen_inc   = seen_q + ssm_pkg::CNT_W'(1);
	assign start_full = seen_inc - ssm_pkg::CNT_W'(pat_len_q);
	// a match counts only once pattern_length bytes are in, and never past saturation
	assign rec_match  = !saturated && win_hit &&
		(seen_inc >= ssm_pkg::CNT_W'(pat_len_q)) && (rpt_last_q || !have_q);

	assign have_nx = have_q || rec_match;
	assign best_nx = rec_match ? ssm_pkg::MATCH_W'(start_full) : best_q;
	assign ovf_nx  = ovf_q || saturated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (s1_go) begin
			window_q <= window_nx;
			if (item_s1.end_of_text) begin
				// text done: start fresh for the next one
				seen_q <= '0;
				have_q <= 1'b0;
				best_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				seen_q <= saturated ? seen_q : seen_inc;
				have_q <= have_nx;
				best_q <= best_nx;
				ovf_q  <= ovf_nx;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && item_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.end_of_text) begin
			out_item_q.found             <= have_nx;
			out_item_q.match_start       <= have_nx ? best_nx : '0;
			out_item_q.position_overflow <= ovf_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
